>>> rtl/alp_pkg.sv
// ----------------------------------------------------------------------------
// Address-list payload parser package
// Shared result codes, configuration indexes, reset values and result types.
// ----------------------------------------------------------------------------
package alp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDR_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IPV4_ID         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IPV6_ID         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONION_V3_ID     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_I2P_ID          = 3'd5;

    localparam logic [15:0] MAX_ENTRIES_RST     = 16'd1000;
    localparam logic [9:0]  MAX_ADDR_LENGTH_RST = 10'd512;
    localparam logic [7:0]  IPV4_ID_RST         = 8'd1;
    localparam logic [7:0]  IPV6_ID_RST         = 8'd2;
    localparam logic [7:0]  ONION_V3_ID_RST     = 8'd4;
    localparam logic [7:0]  I2P_ID_RST          = 8'd5;

    localparam logic [7:0] CS_MARK_16 = 8'd253;
    localparam logic [7:0] CS_MARK_32 = 8'd254;

    localparam logic [9:0] IPV4_LEN   = 10'd4;
    localparam logic [9:0] IPV6_LEN   = 10'd16;
    localparam logic [9:0] KEY32_LEN  = 10'd32;

    localparam int RES_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        NET_IPV4     = 2'd0,
        NET_IPV6     = 2'd1,
        NET_ONION_V3 = 2'd2,
        NET_I2P      = 2'd3
    } net_t;

    typedef enum logic [1:0] {
        KIND_ADDR   = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_COUNT_CUT  = 4'd1,
        ST_TOO_MANY   = 4'd2,
        ST_TIME_CUT   = 4'd3,
        ST_SVC_CUT    = 4'd4,
        ST_NETID_CUT  = 4'd5,
        ST_LEN_CUT    = 4'd6,
        ST_LEN_BIG    = 4'd7,
        ST_ADDR_CUT   = 4'd8
    } status_t;

    typedef struct packed {
        logic [1:0]  pad;
        status_t     status;
        logic [15:0] entry_port;
        net_t        network_kind;
        logic [63:0] entry_services;
        logic [31:0] entry_time;
        logic [7:0]  addr_byte;
    } result_data_t;

    typedef struct packed {
        logic         last_result;
        kind_t        result_kind;
        result_data_t data;
    } result_t;

endpackage

>>> rtl/addr_list_payload_parser_top.sv
// ----------------------------------------------------------------------------
// Address-list payload parser
// Usage: payload bytes enter on the s_ channel, one request per byte. s_tuser
// says whether the request carries a byte (0 is a bare end marker) and s_tlast
// ends the payload after that request. Results leave on the m_ channel:
// m_tuser gives the kind (address byte, entry complete, payload status) and
// m_tlast marks the status that closes each payload. Address bytes of a kept
// entry come out as they arrive; the last port byte of a kept entry gives an
// entry result.
// A result is offered once its request has passed the input register and has
// been written into the result queue. One request is taken every cycle while
// the queue has room; a request that yields an address or entry result and also
// ends the payload gives two results, both queued in the same cycle.
// Results wait in a four-entry queue. The input stalls while more than two
// results would remain queued after this cycle's take, so a stalled receiver
// fills the queue and then drops s_tready; nothing is lost.
// The configuration port writes one register per cycle with cfg_we. Reset
// restores the register defaults and starts a new payload.
// ----------------------------------------------------------------------------
module addr_list_payload_parser_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [alp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [alp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // data_byte
    input  logic                                s_tuser,   // byte_present
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [127:0]                        m_tdata,   // addr_byte, entry_time,
                                                           // entry_services,
                                                           // network_kind, entry_port,
                                                           // status, zero pad
    output logic [1:0]                          m_tuser,   // result_kind
    output logic                                m_tlast
);

    localparam int DEPTH = alp_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        PH_COUNT_MARK,
        PH_COUNT_EXT,
        PH_TIME,
        PH_SVC_MARK,
        PH_SVC_EXT,
        PH_NETID,
        PH_LEN_MARK,
        PH_LEN_EXT,
        PH_ADDR,
        PH_PORT,
        PH_DONE
    } phase_t;

    function automatic alp_pkg::status_t cut_code(input phase_t ph);
        alp_pkg::status_t st;
        case (ph)
            PH_COUNT_MARK, PH_COUNT_EXT: st = alp_pkg::ST_COUNT_CUT;
            PH_TIME:                     st = alp_pkg::ST_TIME_CUT;
            PH_SVC_MARK, PH_SVC_EXT:     st = alp_pkg::ST_SVC_CUT;
            PH_NETID:                    st = alp_pkg::ST_NETID_CUT;
            PH_LEN_MARK, PH_LEN_EXT:     st = alp_pkg::ST_LEN_CUT;
            PH_ADDR, PH_PORT:            st = alp_pkg::ST_ADDR_CUT;
            default:                     st = alp_pkg::ST_OK;
        endcase
        return st;
    endfunction

    function automatic logic [9:0] expected_len(input alp_pkg::net_t net);
        logic [9:0] len;
        case (net)
            alp_pkg::NET_IPV4: len = alp_pkg::IPV4_LEN;
            alp_pkg::NET_IPV6: len = alp_pkg::IPV6_LEN;
            default:           len = alp_pkg::KEY32_LEN;
        endcase
        return len;
    endfunction

    // Configuration registers
    logic [15:0] max_entries_reg;
    logic [9:0]  max_addr_length_reg;
    logic [7:0]  ipv4_id_reg;
    logic [7:0]  ipv6_id_reg;
    logic [7:0]  onion_v3_id_reg;
    logic [7:0]  i2p_id_reg;

    // Input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_end_reg;

    // Parse state
    phase_t            phase_reg,     phase_next;
    logic [3:0]        vleft_reg,     vleft_next;
    logic [3:0]        bidx_reg,      bidx_next;
    logic [63:0]       acc_reg,       acc_next;
    logic [15:0]       entries_reg,   entries_next;
    logic [31:0]       time_reg,      time_next;
    logic [63:0]       svc_reg,       svc_next;
    alp_pkg::net_t     net_reg,       net_next;
    logic [9:0]        addr_left_reg, addr_left_next;
    logic [7:0]        port_hi_reg,   port_hi_next;
    logic              kept_reg,      kept_next;
    alp_pkg::status_t  lstat_reg,     lstat_next;

    // Result queue
    alp_pkg::result_t  fifo_mem [DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              pop;
    logic [CNT_W-1:0]  count_after_pop;
    logic              fire;
    logic [7:0]        b;
    logic              vdone;
    logic [63:0]       vval;
    logic [63:0]       acc_merged;
    logic              item_vld;
    alp_pkg::result_t  item_res;
    alp_pkg::result_t  stat_res;
    alp_pkg::result_t  slot0;
    logic [1:0]        n_res;

    assign pop             = m_tvalid && m_tready;
    assign count_after_pop = count_reg - CNT_W'(pop);
    assign fire            = in_vld_reg && (count_after_pop <= CNT_W'(DEPTH - 2));
    assign s_tready        = !in_vld_reg || fire;

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg].data;
    assign m_tuser  = fifo_mem[rd_ptr_reg].result_kind;
    assign m_tlast  = fifo_mem[rd_ptr_reg].last_result;

    assign b          = in_byte_reg;
    assign acc_merged = acc_reg | ({56'd0, b} << {bidx_reg[2:0], 3'b000});

    always_comb
    begin
        phase_next     = phase_reg;
        vleft_next     = vleft_reg;
        bidx_next      = bidx_reg;
        acc_next       = acc_reg;
        entries_next   = entries_reg;
        time_next      = time_reg;
        svc_next       = svc_reg;
        net_next       = net_reg;
        addr_left_next = addr_left_reg;
        port_hi_next   = port_hi_reg;
        kept_next      = kept_reg;
        lstat_next     = lstat_reg;
        vdone          = 1'b0;
        vval           = {56'd0, b};
        item_vld       = 1'b0;
        item_res       = '0;
        stat_res       = '0;

        if (fire && in_present_reg)
        begin
            case (phase_reg)
                PH_COUNT_MARK, PH_SVC_MARK, PH_LEN_MARK:
                begin
                    if (b < alp_pkg::CS_MARK_16)
                    begin
                        vdone = 1'b1;
                    end
                    else
                    begin
                        vleft_next = (b == alp_pkg::CS_MARK_16) ? 4'd2 :
                                     (b == alp_pkg::CS_MARK_32) ? 4'd4 : 4'd8;
                        bidx_next  = '0;
                        acc_next   = '0;
                        case (phase_reg)
                            PH_COUNT_MARK: phase_next = PH_COUNT_EXT;
                            PH_SVC_MARK:   phase_next = PH_SVC_EXT;
                            default:       phase_next = PH_LEN_EXT;
                        endcase
                    end
                end
                PH_COUNT_EXT, PH_SVC_EXT, PH_LEN_EXT:
                begin
                    acc_next   = acc_merged;
                    bidx_next  = bidx_reg + 4'd1;
                    vleft_next = vleft_reg - 4'd1;
                    vval       = acc_merged;
                    vdone      = (vleft_reg == 4'd1);
                end
                PH_TIME:
                begin
                    time_next = time_reg | ({24'd0, b} << {bidx_reg[1:0], 3'b000});
                    bidx_next = bidx_reg + 4'd1;
                    if (bidx_reg == 4'd3)
                    begin
                        phase_next = PH_SVC_MARK;
                    end
                end
                PH_NETID:
                begin
                    kept_next = 1'b1;
                    if (b == ipv4_id_reg)
                    begin
                        net_next = alp_pkg::NET_IPV4;
                    end
                    else if (b == ipv6_id_reg)
                    begin
                        net_next = alp_pkg::NET_IPV6;
                    end
                    else if (b == onion_v3_id_reg)
                    begin
                        net_next = alp_pkg::NET_ONION_V3;
                    end
                    else if (b == i2p_id_reg)
                    begin
                        net_next = alp_pkg::NET_I2P;
                    end
                    else
                    begin
                        net_next  = alp_pkg::NET_IPV4;
                        kept_next = 1'b0;
                    end
                    phase_next = PH_LEN_MARK;
                end
                PH_ADDR:
                begin
                    if (kept_reg)
                    begin
                        item_vld                = 1'b1;
                        item_res.result_kind    = alp_pkg::KIND_ADDR;
                        item_res.data.addr_byte = b;
                    end
                    addr_left_next = addr_left_reg - 10'd1;
                    if (addr_left_reg == 10'd1)
                    begin
                        phase_next = PH_PORT;
                    end
                end
                PH_PORT:
                begin
                    if (bidx_reg == 4'd0)
                    begin
                        port_hi_next = b;
                        bidx_next    = 4'd1;
                    end
                    else
                    begin
                        if (kept_reg)
                        begin
                            item_vld                     = 1'b1;
                            item_res.result_kind         = alp_pkg::KIND_ENTRY;
                            item_res.data.entry_time     = time_reg;
                            item_res.data.entry_services = svc_reg;
                            item_res.data.network_kind   = net_reg;
                            item_res.data.entry_port     = {port_hi_reg, b};
                        end
                        entries_next = entries_reg - 16'd1;
                        if (entries_reg == 16'd1)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_TIME;
                            bidx_next  = '0;
                            time_next  = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (vdone)
            begin
                if (phase_reg inside {PH_COUNT_MARK, PH_COUNT_EXT})
                begin
                    if (vval > {48'd0, max_entries_reg})
                    begin
                        lstat_next = alp_pkg::ST_TOO_MANY;
                        phase_next = PH_DONE;
                    end
                    else if (vval == 64'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        entries_next = vval[15:0];
                        phase_next   = PH_TIME;
                        bidx_next    = '0;
                        time_next    = '0;
                    end
                end
                else if (phase_reg inside {PH_SVC_MARK, PH_SVC_EXT})
                begin
                    svc_next   = vval;
                    phase_next = PH_NETID;
                end
                else
                begin
                    if (vval > {54'd0, max_addr_length_reg})
                    begin
                        lstat_next = alp_pkg::ST_LEN_BIG;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        addr_left_next = vval[9:0];
                        kept_next      = kept_reg &&
                                         (vval[9:0] == expected_len(net_reg));
                        phase_next     = (vval != 64'd0) ? PH_ADDR : PH_PORT;
                        bidx_next      = '0;
                        port_hi_next   = '0;
                    end
                end
            end
        end

        stat_res.result_kind = alp_pkg::KIND_STATUS;
        stat_res.last_result = 1'b1;
        stat_res.data.status = (lstat_next != alp_pkg::ST_OK) ? lstat_next :
                               cut_code(phase_next);

        if (fire && in_end_reg)
        begin
            phase_next     = PH_COUNT_MARK;
            vleft_next     = '0;
            bidx_next      = '0;
            acc_next       = '0;
            entries_next   = '0;
            time_next      = '0;
            svc_next       = '0;
            net_next       = alp_pkg::NET_IPV4;
            addr_left_next = '0;
            port_hi_next   = '0;
            kept_next      = 1'b0;
            lstat_next     = alp_pkg::ST_OK;
        end

        slot0 = item_vld ? item_res : stat_res;
        n_res = fire ? ({1'b0, item_vld} + {1'b0, in_end_reg}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg     <= alp_pkg::MAX_ENTRIES_RST;
            max_addr_length_reg <= alp_pkg::MAX_ADDR_LENGTH_RST;
            ipv4_id_reg         <= alp_pkg::IPV4_ID_RST;
            ipv6_id_reg         <= alp_pkg::IPV6_ID_RST;
            onion_v3_id_reg     <= alp_pkg::ONION_V3_ID_RST;
            i2p_id_reg          <= alp_pkg::I2P_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                alp_pkg::CFG_MAX_ENTRIES:     max_entries_reg     <= cfg_data;
                alp_pkg::CFG_MAX_ADDR_LENGTH: max_addr_length_reg <= cfg_data[9:0];
                alp_pkg::CFG_IPV4_ID:         ipv4_id_reg         <= cfg_data[7:0];
                alp_pkg::CFG_IPV6_ID:         ipv6_id_reg         <= cfg_data[7:0];
                alp_pkg::CFG_ONION_V3_ID:     onion_v3_id_reg     <= cfg_data[7:0];
                alp_pkg::CFG_I2P_ID:          i2p_id_reg          <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            phase_reg      <= PH_COUNT_MARK;
            vleft_reg      <= '0;
            bidx_reg       <= '0;
            acc_reg        <= '0;
            entries_reg    <= '0;
            time_reg       <= '0;
            svc_reg        <= '0;
            net_reg        <= alp_pkg::NET_IPV4;
            addr_left_reg  <= '0;
            port_hi_reg    <= '0;
            kept_reg       <= 1'b0;
            lstat_reg      <= alp_pkg::ST_OK;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            phase_reg     <= phase_next;
            vleft_reg     <= vleft_next;
            bidx_reg      <= bidx_next;
            acc_reg       <= acc_next;
            entries_reg   <= entries_next;
            time_reg      <= time_next;
            svc_reg       <= svc_next;
            net_reg       <= net_next;
            addr_left_reg <= addr_left_next;
            port_hi_reg   <= port_hi_next;
            kept_reg      <= kept_next;
            lstat_reg     <= lstat_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            count_reg  <= count_after_pop + CNT_W'(n_res);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_end_reg     <= s_tlast;
        end
        if (n_res != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (n_res == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= stat_res;
        end
    end

endmodule
